// ===== sv/delta_list_timer_queue_core_assert.svh =====
// Assertion macros for the delta list timer queue core.
// Included by the top level; the macros expect i_clk and i_rst_n in scope.
`ifndef DELTA_LIST_TIMER_QUEUE_CORE_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define DLTQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define DLTQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dltq_pkg.sv =====
// Shared types and constants for the delta list timer queue core.
// No dependencies; used by delta_list_timer_queue_core.
package dltq_pkg;

    // Default pool size, register reset values and the wait hint for an empty queue.
    localparam int unsigned POOL_ENTRIES_DEF = 16;
    localparam logic [31:0] MAX_WAIT_RST     = 32'd1000;
    localparam logic [7:0]  FIRE_SLACK_RST   = 8'd2;
    localparam logic [31:0] EMPTY_WAIT       = 32'hFFFF_FFFF;

    // Configuration port address width (two registers at byte addresses 0 and 4).
    localparam int unsigned APB_ADDR_W = 3;

    // Register select, taken from the word address bit.
    typedef enum logic {
        REG_MAX_WAIT   = 1'b0,
        REG_FIRE_SLACK = 1'b1
    } t_reg_sel;

    // Item function codes.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // Input item.
    typedef struct packed {
        logic        func;
        logic [31:0] elapsed;
        logic [1:0]  task_kind;
        logic [15:0] task_tag;
        logic [31:0] timeout;
        logic [31:0] repeat_interval;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic        fired;
        logic [1:0]  fired_kind;
        logic [15:0] fired_tag;
        logic [31:0] wait_hint;
        logic [4:0]  queued_count;
        logic        dropped;
    } t_out_item;

    // Per-entry payload held in the payload memory.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] tag;
        logic [31:0] reload;
    } t_pay_ent;

endpackage

// ===== sv/delta_list_timer_queue_core.sv =====
// Delta list timer queue: a pool of timer entries on a linked ring, serviced by a
// small sequencer around one shared 32-bit subtract and compare unit.
// Depends on dltq_pkg and delta_list_timer_queue_core_assert.svh.
//
// Usage: items enter on i_in_valid/o_in_stall with an i_in_item payload; each item
// yields exactly one result on o_out_valid/i_out_stall with an o_out_item payload.
// Registers max_wait (byte address 0) and fire_slack (byte address 4) are written
// through the APB-style port, which is always ready.
// One item is worked on at a time; o_in_stall is high from acceptance until its
// result has been loaded into the output register.
// Work per item: a tick without firing goes straight to the result; a tick that
//   fires also unlinks the head and reads the next head's delta, then inserts the
//   entry again when it repeats;
//   an insert into an empty or full pool goes straight to the result;
//   an insert behind the head walks the queue, entry by entry, to its place;
//   an insert in front of the head walks the free slots to the slot before the head.
// The walk is set by the single-ported link and delta memories, one read per cycle.
// Reset empties the queue at once; the link ring uses per-slot valid bits, so there
// is no clearing pass. A stalled result is held in the output register while the
// next item is accepted and worked on; that item's result waits until it is taken.
`include "delta_list_timer_queue_core_assert.svh"

module delta_list_timer_queue_core #(
    parameter int unsigned POOL_ENTRIES = dltq_pkg::POOL_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dltq_pkg::t_in_item                i_in_item,
    // Result output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dltq_pkg::t_out_item               o_out_item,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dltq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int unsigned SLOT_W = $clog2(POOL_ENTRIES);
    localparam int unsigned CNT_W  = $clog2(POOL_ENTRIES + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(POOL_ENTRIES - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(POOL_ENTRIES);

    // Sequencer states, one-hot.
    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00_0000_0000_0001,
        ST_TICK    = 14'b00_0000_0000_0010,
        ST_POP     = 14'b00_0000_0000_0100,
        ST_POP2    = 14'b00_0000_0000_1000,
        ST_INS     = 14'b00_0000_0001_0000,
        ST_INS_T   = 14'b00_0000_0010_0000,
        ST_INS_TN  = 14'b00_0000_0100_0000,
        ST_PRED    = 14'b00_0000_1000_0000,
        ST_WALK_B  = 14'b00_0001_0000_0000,
        ST_WALK_C  = 14'b00_0010_0000_0000,
        ST_SPLIT   = 14'b00_0100_0000_0000,
        ST_LINK_T  = 14'b00_1000_0000_0000,
        ST_LINK_P  = 14'b01_0000_0000_0000,
        ST_DONE    = 14'b10_0000_0000_0000
    } t_state;

    // Control registers
    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_head, n_head;
    logic [SLOT_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_vld;
    logic [31:0]        r_max_wait;
    logic [7:0]         r_fire_slack;
    logic [POOL_ENTRIES-1:0] r_lnk_vld;

    // Datapath registers
    logic [31:0]        r_head_dly, n_head_dly;
    logic [1:0]         r_ins_kind, n_ins_kind;
    logic [15:0]        r_ins_tag, n_ins_tag;
    logic [31:0]        r_ins_tmo, n_ins_tmo;
    logic [31:0]        r_ins_rld, n_ins_rld;
    logic [31:0]        r_elapsed, n_elapsed;
    logic [SLOT_W-1:0]  r_t, n_t;
    logic [SLOT_W-1:0]  r_tnext, n_tnext;
    logic [SLOT_W-1:0]  r_prev, n_prev;
    logic [SLOT_W-1:0]  r_pred, n_pred;
    logic [SLOT_W-1:0]  r_succ, n_succ;
    logic [31:0]        r_rem, n_rem;
    logic [CNT_W-1:0]   r_k, n_k;
    logic               r_front, n_front;
    logic               r_last, n_last;
    logic               r_fired, n_fired;
    logic [1:0]         r_fkind, n_fkind;
    logic [15:0]        r_ftag, n_ftag;
    logic               r_dropped, n_dropped;
    dltq_pkg::t_out_item r_out, n_out;

    // Memories and their registered read data
    logic [31:0]        m_delta [POOL_ENTRIES];
    dltq_pkg::t_pay_ent m_pay   [POOL_ENTRIES];
    logic [SLOT_W-1:0]  m_link  [POOL_ENTRIES];
    logic [31:0]        r_delta_rd;
    dltq_pkg::t_pay_ent r_pay_rd;
    logic [SLOT_W-1:0]  r_link_rd;

    // Memory port controls
    logic               dly_re, dly_we;
    logic [SLOT_W-1:0]  dly_ra, dly_wa;
    logic [31:0]        dly_wd;
    logic               pay_re, pay_we;
    logic [SLOT_W-1:0]  pay_ra, pay_wa;
    dltq_pkg::t_pay_ent pay_wd;
    logic               lnk_re, lnk_we;
    logic [SLOT_W-1:0]  lnk_ra, lnk_wa, lnk_wd;
    logic [SLOT_W-1:0]  lnk_ra_next;

    // Shared subtract and compare unit
    logic [31:0]        sub_a, sub_b, sub_diff;
    logic               sub_borrow;
    logic [31:0]        tick_dly;
    logic               fire_hit;
    logic               out_load;
    logic               cfg_wr;

    // Handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_wait   <= dltq_pkg::MAX_WAIT_RST;
            r_fire_slack <= dltq_pkg::FIRE_SLACK_RST;
        end else if (cfg_wr) begin
            case (dltq_pkg::t_reg_sel'(paddr[2]))
                dltq_pkg::REG_MAX_WAIT:   r_max_wait   <= pwdata;
                dltq_pkg::REG_FIRE_SLACK: r_fire_slack <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (dltq_pkg::t_reg_sel'(paddr[2]))
            dltq_pkg::REG_MAX_WAIT:   prdata = r_max_wait;
            dltq_pkg::REG_FIRE_SLACK: prdata = {24'd0, r_fire_slack};
            default:                  prdata = '0;
        endcase
    end

    // Operand selection for the shared unit, by sequencer state.
    always_comb begin
        sub_a = r_head_dly;
        sub_b = r_elapsed;
        case (r_state)
            ST_TICK: begin
                sub_a = r_head_dly;
                sub_b = r_elapsed;
            end
            ST_INS_TN: begin
                sub_a = r_ins_tmo;
                sub_b = r_head_dly;
            end
            ST_PRED: begin
                sub_a = r_head_dly;
                sub_b = r_ins_tmo;
            end
            ST_WALK_C: begin
                sub_a = r_rem;
                sub_b = r_delta_rd;
            end
            ST_SPLIT: begin
                sub_a = r_delta_rd;
                sub_b = r_rem;
            end
            ST_DONE: begin
                sub_a = r_max_wait;
                sub_b = r_head_dly;
            end
            default: ;
        endcase
    end

    // A borrow means sub_a is below sub_b.
    assign {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};

    // Saturated head remainder after a tick, and the firing test against the slack.
    assign tick_dly = sub_borrow ? '0 : sub_diff;
    assign fire_hit = (tick_dly[31:8] == '0) && (tick_dly[7:0] <= r_fire_slack);

    // Payload written for a new entry always comes from the insert operands.
    always_comb begin
        pay_wd.kind   = r_ins_kind;
        pay_wd.tag    = r_ins_tag;
        pay_wd.reload = r_ins_rld;
    end

    // Result assembled from the finished item.
    always_comb begin
        n_out.fired        = r_fired;
        n_out.fired_kind   = r_fkind;
        n_out.fired_tag    = r_ftag;
        n_out.queued_count = 5'(r_count);
        n_out.dropped      = r_dropped;
        if (r_count == '0) begin
            n_out.wait_hint = dltq_pkg::EMPTY_WAIT;
        end else if (sub_borrow) begin
            n_out.wait_hint = r_max_wait;
        end else begin
            n_out.wait_hint = r_head_dly;
        end
    end

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_head_dly = r_head_dly;
        n_ins_kind = r_ins_kind;
        n_ins_tag  = r_ins_tag;
        n_ins_tmo  = r_ins_tmo;
        n_ins_rld  = r_ins_rld;
        n_elapsed  = r_elapsed;
        n_t        = r_t;
        n_tnext    = r_tnext;
        n_prev     = r_prev;
        n_pred     = r_pred;
        n_succ     = r_succ;
        n_rem      = r_rem;
        n_k        = r_k;
        n_front    = r_front;
        n_last     = r_last;
        n_fired    = r_fired;
        n_fkind    = r_fkind;
        n_ftag     = r_ftag;
        n_dropped  = r_dropped;
        dly_re     = 1'b0;
        dly_ra     = r_link_rd;
        dly_we     = 1'b0;
        dly_wa     = r_head;
        dly_wd     = sub_diff;
        pay_re     = 1'b0;
        pay_ra     = r_head;
        pay_we     = 1'b0;
        pay_wa     = r_t;
        lnk_re     = 1'b0;
        lnk_ra     = r_tail;
        lnk_we     = 1'b0;
        lnk_wa     = r_tail;
        lnk_wd     = r_t;
        out_load   = 1'b0;

        case (r_state)
            // Take a new item and latch its operands.
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_ins_kind = i_in_item.task_kind;
                    n_ins_tag  = i_in_item.task_tag;
                    n_ins_tmo  = i_in_item.timeout;
                    n_ins_rld  = i_in_item.repeat_interval;
                    n_elapsed  = i_in_item.elapsed;
                    n_fired    = 1'b0;
                    n_fkind    = '0;
                    n_ftag     = '0;
                    n_dropped  = 1'b0;
                    n_state    = (i_in_item.func == dltq_pkg::FUNC_TICK) ? ST_TICK : ST_INS;
                end
            end

            // Lower the head remainder and decide whether the head fires.
            ST_TICK: begin
                if (r_count == '0) begin
                    n_state = ST_DONE;
                end else begin
                    dly_we     = 1'b1;
                    dly_wa     = r_head;
                    dly_wd     = tick_dly;
                    n_head_dly = tick_dly;
                    if (fire_hit) begin
                        pay_re  = 1'b1;
                        pay_ra  = r_head;
                        lnk_re  = 1'b1;
                        lnk_ra  = r_head;
                        n_state = ST_POP;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end

            // Unlink the head and report it; fetch the new head's delta.
            ST_POP: begin
                n_head  = r_link_rd;
                n_count = r_count - CNT_W'(1);
                n_fired = 1'b1;
                n_fkind = r_pay_rd.kind;
                n_ftag  = r_pay_rd.tag;
                dly_re  = 1'b1;
                dly_ra  = r_link_rd;
                n_state = ST_POP2;
            end

            // Cache the new head delta and re-queue a repeating entry.
            ST_POP2: begin
                n_head_dly = r_delta_rd;
                if (r_pay_rd.reload != '0) begin
                    n_ins_kind = r_pay_rd.kind;
                    n_ins_tag  = r_pay_rd.tag;
                    n_ins_tmo  = r_pay_rd.reload;
                    n_ins_rld  = r_pay_rd.reload;
                    n_state    = ST_INS;
                end else begin
                    n_state = ST_DONE;
                end
            end

            // Insert: full pool, empty queue, or fetch the first free slot.
            ST_INS: begin
                n_front = 1'b0;
                if (r_count == FULL_COUNT) begin
                    n_dropped = 1'b1;
                    n_state   = ST_DONE;
                end else if (r_count == '0) begin
                    pay_we     = 1'b1;
                    pay_wa     = r_head;
                    dly_we     = 1'b1;
                    dly_wa     = r_head;
                    dly_wd     = r_ins_tmo;
                    n_tail     = r_head;
                    n_count    = CNT_W'(1);
                    n_head_dly = r_ins_tmo;
                    n_state    = ST_DONE;
                end else begin
                    lnk_re  = 1'b1;
                    lnk_ra  = r_tail;
                    n_state = ST_INS_T;
                end
            end

            // The free slot is known: store its payload and fetch its link.
            ST_INS_T: begin
                n_t     = r_link_rd;
                pay_we  = 1'b1;
                pay_wa  = r_link_rd;
                lnk_re  = 1'b1;
                lnk_ra  = r_link_rd;
                n_state = ST_INS_TN;
            end

            // Take the slot off the free ring and choose front or walk.
            ST_INS_TN: begin
                n_tnext = r_link_rd;
                lnk_we  = 1'b1;
                lnk_wa  = r_tail;
                lnk_wd  = r_link_rd;
                if (sub_borrow) begin
                    n_pred  = r_tail;
                    n_state = ST_PRED;
                end else begin
                    n_rem  = sub_diff;
                    n_prev = r_head;
                    n_k    = '0;
                    if (r_count == CNT_W'(1)) begin
                        n_succ  = r_link_rd;
                        n_last  = 1'b1;
                        n_state = ST_LINK_T;
                    end else begin
                        lnk_re  = 1'b1;
                        lnk_ra  = r_head;
                        n_state = ST_WALK_B;
                    end
                end
            end

            // Walk the ring from the tail to the slot just before the head.
            ST_PRED: begin
                if (r_link_rd == r_head) begin
                    lnk_we  = 1'b1;
                    lnk_wa  = r_pred;
                    lnk_wd  = r_t;
                    dly_we  = 1'b1;
                    dly_wa  = r_head;
                    dly_wd  = sub_diff;
                    n_rem   = r_ins_tmo;
                    n_succ  = r_head;
                    n_front = 1'b1;
                    n_state = ST_LINK_T;
                end else begin
                    n_pred = r_link_rd;
                    lnk_re = 1'b1;
                    lnk_ra = r_link_rd;
                end
            end

            // Successor slot known: fetch its delta.
            ST_WALK_B: begin
                dly_re  = 1'b1;
                dly_ra  = r_link_rd;
                n_state = ST_WALK_C;
            end

            // Compare the remainder with the successor delta and step on.
            ST_WALK_C: begin
                if (sub_borrow) begin
                    n_state = ST_SPLIT;
                end else begin
                    n_rem  = sub_diff;
                    n_prev = r_link_rd;
                    n_k    = r_k + CNT_W'(1);
                    if ((r_k + CNT_W'(2)) == r_count) begin
                        n_succ  = r_tnext;
                        n_last  = 1'b1;
                        n_state = ST_LINK_T;
                    end else begin
                        lnk_re  = 1'b1;
                        lnk_ra  = r_link_rd;
                        n_state = ST_WALK_B;
                    end
                end
            end

            // Reduce the successor's delta by the new entry's delta.
            ST_SPLIT: begin
                dly_we  = 1'b1;
                dly_wa  = r_link_rd;
                dly_wd  = sub_diff;
                n_succ  = r_link_rd;
                n_last  = 1'b0;
                n_state = ST_LINK_T;
            end

            // Write the new entry's delta and link.
            ST_LINK_T: begin
                dly_we = 1'b1;
                dly_wa = r_t;
                dly_wd = r_rem;
                lnk_we = 1'b1;
                lnk_wa = r_t;
                lnk_wd = r_succ;
                if (r_front) begin
                    n_head     = r_t;
                    n_head_dly = r_rem;
                    n_count    = r_count + CNT_W'(1);
                    n_state    = ST_DONE;
                end else begin
                    n_state = ST_LINK_P;
                end
            end

            // Point the previous entry at the new one.
            ST_LINK_P: begin
                lnk_we  = 1'b1;
                lnk_wa  = r_prev;
                lnk_wd  = r_t;
                if (r_last) begin
                    n_tail = r_t;
                end
                n_count = r_count + CNT_W'(1);
                n_state = ST_DONE;
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_head_dly <= n_head_dly;
        r_ins_kind <= n_ins_kind;
        r_ins_tag  <= n_ins_tag;
        r_ins_tmo  <= n_ins_tmo;
        r_ins_rld  <= n_ins_rld;
        r_elapsed  <= n_elapsed;
        r_t        <= n_t;
        r_tnext    <= n_tnext;
        r_prev     <= n_prev;
        r_pred     <= n_pred;
        r_succ     <= n_succ;
        r_rem      <= n_rem;
        r_k        <= n_k;
        r_front    <= n_front;
        r_last     <= n_last;
        r_fired    <= n_fired;
        r_fkind    <= n_fkind;
        r_ftag     <= n_ftag;
        r_dropped  <= n_dropped;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // Delta memory.
    always_ff @(posedge i_clk) begin
        if (dly_we) begin
            m_delta[dly_wa] <= dly_wd;
        end
        if (dly_re) begin
            r_delta_rd <= m_delta[dly_ra];
        end
    end

    // Payload memory: kind, tag and reload of each entry.
    always_ff @(posedge i_clk) begin
        if (pay_we) begin
            m_pay[pay_wa] <= pay_wd;
        end
        if (pay_re) begin
            r_pay_rd <= m_pay[pay_ra];
        end
    end

    // Link memory; a slot never written reads as the next slot round the ring.
    assign lnk_ra_next = (lnk_ra == LAST_SLOT) ? '0 : lnk_ra + SLOT_W'(1);

    always_ff @(posedge i_clk) begin
        if (lnk_we) begin
            m_link[lnk_wa] <= lnk_wd;
        end
        if (lnk_re) begin
            r_link_rd <= r_lnk_vld[lnk_ra] ? m_link[lnk_ra] : lnk_ra_next;
        end
    end

    // Link valid bits, cleared at reset to restore the initial ring.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lnk_vld <= '0;
        end else if (lnk_we) begin
            r_lnk_vld[lnk_wa] <= 1'b1;
        end
    end

    // Checks on the sequencer's bookkeeping.
    `DLTQ_ASSERT_IMP(a_count_bound, 1'b1, r_count <= FULL_COUNT, "entry count exceeds the pool")
    `DLTQ_ASSERT_IMP(a_drop_full, out_load && r_dropped, r_count == FULL_COUNT, "drop with free slots")
    `DLTQ_ASSERT_IMP(a_walk_range, r_state == ST_WALK_B || r_state == ST_WALK_C, (r_k + CNT_W'(1)) < r_count, "walk ran past the tail")
    `DLTQ_ASSERT_NXT(a_pop_dec, r_state == ST_POP, r_count == $past(r_count) - CNT_W'(1), "pop did not shrink the queue")

endmodule
